/* sv/pbfd_pkg.sv */
// pbfd_pkg: shared types and constants of the density/lambda accumulator.
// No dependencies; imported by pbfd_datapath, pbfd_ctrl and the top level.
package pbfd_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_RADIUS = 3'd0;
    localparam logic [2:0] REG_POLY6  = 3'd1;
    localparam logic [2:0] REG_SPIKY  = 3'd2;
    localparam logic [2:0] REG_MASS   = 3'd3;
    localparam logic [2:0] REG_RHO    = 3'd4;
    localparam logic [2:0] REG_EPS    = 3'd5;

    localparam logic [30:0] EPS_RESET = 31'd655;

    // Sequencer steps, in program order (next step is step + 1 unless branched)
    localparam logic [4:0] ST_R2X   = 5'd0;
    localparam logic [4:0] ST_R2Y   = 5'd1;
    localparam logic [4:0] ST_R2Z   = 5'd2;
    localparam logic [4:0] ST_H2    = 5'd3;
    localparam logic [4:0] ST_P1    = 5'd4;
    localparam logic [4:0] ST_P2    = 5'd5;
    localparam logic [4:0] ST_P3    = 5'd6;
    localparam logic [4:0] ST_P4    = 5'd7;
    localparam logic [4:0] ST_SQRT  = 5'd8;
    localparam logic [4:0] ST_HR2   = 5'd9;
    localparam logic [4:0] ST_QDIV  = 5'd10;
    localparam logic [4:0] ST_CM    = 5'd11;
    localparam logic [4:0] ST_GX    = 5'd12;
    localparam logic [4:0] ST_SQX   = 5'd13;
    localparam logic [4:0] ST_GY    = 5'd14;
    localparam logic [4:0] ST_SQY   = 5'd15;
    localparam logic [4:0] ST_GZ    = 5'd16;
    localparam logic [4:0] ST_SQZ   = 5'd17;
    localparam logic [4:0] ST_TX    = 5'd18;
    localparam logic [4:0] ST_TY    = 5'd19;
    localparam logic [4:0] ST_TZ    = 5'd20;
    localparam logic [4:0] ST_KDIV  = 5'd21;
    localparam logic [4:0] ST_KK    = 5'd22;
    localparam logic [4:0] ST_DEN   = 5'd23;
    localparam logic [4:0] ST_RATIO = 5'd24;
    localparam logic [4:0] ST_LAM   = 5'd25;

    typedef struct packed {
        logic [30:0]        radius;
        logic [30:0]        poly6;
        logic signed [31:0] spiky;
        logic [30:0]        mass;
        logic [30:0]        rho;
        logic [30:0]        eps;
    } cfg_t;

    typedef struct packed {
        logic       load;    // input beat taken this cycle
        logic       issue;   // start the unit of this step
        logic       commit;  // write back the result of this step
        logic [4:0] step;
    } cmd_t;

    typedef struct packed {
        logic busy;       // an arithmetic unit is working
        logic far;        // pair beyond radius (valid at commit of ST_H2)
        logic skip_grad;  // self or coincident pair
        logic last;       // current beat closes the run
        logic out_free;   // output register can take a result
    } stat_t;

endpackage

/* sv/pbfd_mul.sv */
// pbfd_mul: 64x64 product from four 32x32 partial products, optional
// fixed-point shift with saturation. Depends on nothing.
module pbfd_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic        frac,
    input  logic [63:0] limit,
    output logic        busy,
    output logic [63:0] res,
    output logic        sat
);
    localparam logic [2:0] LAST_PP = 3'd3;
    localparam logic [2:0] LAST_CNT = 3'd5;

    logic [63:0]  a_reg, b_reg, limit_reg, pp_reg, res_reg;
    logic         frac_reg, busy_reg, sat_reg;
    logic [2:0]   cnt_reg;
    logic [1:0]   sh_reg;
    logic [127:0] acc_reg;
    logic [31:0]  a_half, b_half;
    logic [63:0]  pp_next, fr;
    logic [1:0]   sh_next;
    logic [127:0] pp_wide;
    logic         ovf;

    always_comb
    begin
        a_half  = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_half  = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp_next = a_half * b_half;
        sh_next = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
        case (sh_reg)
            2'd0:    pp_wide = {64'd0, pp_reg};
            2'd1:    pp_wide = {32'd0, pp_reg, 32'd0};
            2'd2:    pp_wide = {pp_reg, 64'd0};
            default: pp_wide = '0;
        endcase
        fr  = acc_reg[63+FRAC_BITS:FRAC_BITS];
        ovf = (|acc_reg[127:64+FRAC_BITS]) || (fr > limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == LAST_CNT)
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg     <= a;
            b_reg     <= b;
            frac_reg  <= frac;
            limit_reg <= limit;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg <= LAST_PP)
            begin
                pp_reg <= pp_next;
                sh_reg <= sh_next;
            end
            if (cnt_reg != 3'd0 && cnt_reg < LAST_CNT)
                acc_reg <= acc_reg + pp_wide;
            if (cnt_reg == LAST_CNT)
            begin
                res_reg <= frac_reg ? (ovf ? limit_reg : fr) : acc_reg[63:0];
                sat_reg <= frac_reg & ovf;
            end
        end
    end

    assign busy = busy_reg;
    assign res  = res_reg;
    assign sat  = sat_reg;
endmodule

/* sv/pbfd_div.sv */
// pbfd_div: restoring divider, one quotient bit per cycle; fixed-point
// (num << F) / den with saturation, or plain num / den. Depends on nothing.
module pbfd_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    input  logic        frac,
    input  logic [63:0] limit,
    output logic        busy,
    output logic [63:0] res,
    output logic        sat
);
    localparam logic [6:0] LAST_CNT = 7'd64;

    logic [63:0] den_reg, limit_reg, rem_reg, lo_reg, res_reg;
    logic        busy_reg, sat_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] den_eff, hi_init, lo_init, rem_next;
    logic [64:0] trial;
    logic        qbit, early;

    always_comb
    begin
        den_eff = (den == 64'd0) ? 64'd1 : den;
        hi_init = frac ? (num >> (64 - FRAC_BITS)) : 64'd0;
        lo_init = frac ? (num << FRAC_BITS) : num;
        early   = hi_init >= den_eff;
        trial   = {rem_reg, lo_reg[63]};
        qbit    = trial >= {1'b0, den_reg};
        rem_next = qbit ? 64'(trial - {1'b0, den_reg}) : trial[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= !early;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == LAST_CNT)
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg   <= den_eff;
            limit_reg <= limit;
            rem_reg   <= hi_init;
            lo_reg    <= lo_init;
            res_reg   <= limit;
            sat_reg   <= early;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == LAST_CNT)
            begin
                res_reg <= (lo_reg > limit_reg) ? limit_reg : lo_reg;
                sat_reg <= lo_reg > limit_reg;
            end
            else
            begin
                rem_reg <= rem_next;
                lo_reg  <= {lo_reg[62:0], qbit};
            end
        end
    end

    assign busy = busy_reg;
    assign res  = res_reg;
    assign sat  = sat_reg;
endmodule

/* sv/pbfd_sqrt.sv */
// pbfd_sqrt: floor square root of a 64-bit value, one result bit per cycle.
// Depends on nothing.
module pbfd_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] v,
    output logic        busy,
    output logic [31:0] res
);
    localparam logic [4:0] LAST_CNT = 5'd31;

    logic [63:0] v_reg, res_reg, bit_reg, trial;
    logic        busy_reg;
    logic [4:0]  cnt_reg;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == LAST_CNT)
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= v;
            res_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign res  = res_reg[31:0];
endmodule

/* sv/pbfd_datapath.sv */
// pbfd_datapath: operand selection, accumulators, write-back and output
// register. Depends on pbfd_pkg, pbfd_mul, pbfd_div and pbfd_sqrt.
module pbfd_datapath #(
    parameter int FRAC_BITS = 16,
    parameter int ACC_BITS  = 48
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pbfd_pkg::cmd_t     cmd,
    input  pbfd_pkg::cfg_t     cfg,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic signed [31:0] neighbor_x,
    input  logic signed [31:0] neighbor_y,
    input  logic signed [31:0] neighbor_z,
    input  logic               is_self,
    input  logic               last_neighbor,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [30:0]        density,
    output logic signed [31:0] lambda,
    output logic               overflow,
    output pbfd_pkg::stat_t    stat
);
    import pbfd_pkg::*;

    localparam logic [63:0] AMAX  = 64'((65'd1 << (ACC_BITS - 1)) - 65'd1);
    localparam logic [63:0] AMAX3 = AMAX / 3;
    localparam logic [63:0] SQMAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] ONE   = 64'd1 << FRAC_BITS;
    localparam logic [63:0] ALL1  = {64{1'b1}};
    localparam logic [63:0] LPOS  = 64'h0000_0000_8000_0000;
    localparam logic [63:0] LNEG  = 64'h0000_0000_7FFF_FFFF;

    // saturating unsigned add at 2^63-1; returns the sum, with the sat flag in s
    function automatic logic [63:0] usat(input logic [63:0] a, input logic [63:0] b,
                                         output logic s);
        logic [64:0] t;
        t = {1'b0, a} + {1'b0, b};
        s = t > {1'b0, SQMAX};
        return s ? SQMAX : t[63:0];
    endfunction

    // saturating signed add at +-AMAX
    function automatic logic [ACC_BITS-1:0] sacc(input logic [ACC_BITS-1:0] a,
                                                 input logic [63:0] mag, input logic neg,
                                                 output logic s);
        logic signed [ACC_BITS+1:0] t, m, lim;
        m   = signed'({2'b00, mag[ACC_BITS-1:0]});
        lim = signed'({2'b00, AMAX[ACC_BITS-1:0]});
        t   = signed'({{2{a[ACC_BITS-1]}}, a}) + (neg ? -m : m);
        s   = (t > lim) || (t < -lim);
        if (t > lim)
            t = lim;
        else if (t < -lim)
            t = -lim;
        return t[ACC_BITS-1:0];
    endfunction

    function automatic logic [63:0] sabs(input logic [ACC_BITS-1:0] a);
        logic [ACC_BITS-1:0] m;
        m = a[ACC_BITS-1] ? (~a + 1'b1) : a;
        return 64'(m);
    endfunction

    logic [31:0]         a0_reg, a1_reg, a2_reg, r_reg;
    logic [2:0]          neg_reg;
    logic                beyond_reg, self_reg, last_reg, cpos_reg, sat_reg;
    logic [63:0]         r2_reg, dq_reg, t_reg, q_reg, cm_reg, gm_reg;
    logic [63:0]         kk_reg, den_reg, cmag_reg;
    logic [30:0]         hr_reg, density_reg;
    logic [ACC_BITS-1:0] dsum_reg, gx_reg, gy_reg, gz_reg;
    logic [62:0]         gsq_reg, tot_reg;
    logic                out_valid_reg, overflow_reg;
    logic [31:0]         lambda_reg;

    logic signed [32:0] dx, dy, dz;
    logic [31:0]        ax, ay, az;
    logic [31:0]        spiky_mag;

    logic        m_go, d_go, s_go, m_frac, d_frac;
    logic [63:0] m_a, m_b, m_lim, d_num, d_den, d_lim;
    logic        m_busy, d_busy, s_busy, m_sat, d_sat;
    logic [63:0] m_res, d_res;
    logic [31:0] s_res;

    logic        out_free, unit_sat, add_sat, gneg, dens_clip;
    logic [63:0] add_res, cm_next, lm_mag;
    logic [ACC_BITS-1:0] acc_res, acc_base;
    logic [31:0] lambda_next;

    always_comb
    begin
        dx = signed'({neighbor_x[31], neighbor_x}) - signed'({center_x[31], center_x});
        dy = signed'({neighbor_y[31], neighbor_y}) - signed'({center_y[31], center_y});
        dz = signed'({neighbor_z[31], neighbor_z}) - signed'({center_z[31], center_z});
        ax = dx[32] ? 32'(-dx) : dx[31:0];
        ay = dy[32] ? 32'(-dy) : dy[31:0];
        az = dz[32] ? 32'(-dz) : dz[31:0];
        // magnitude of the spiky factor; -2^31 gives 2^31
        spiky_mag = cfg.spiky[31] ? (~cfg.spiky + 32'd1) : cfg.spiky;
    end

    // operand routing per step
    always_comb
    begin
        m_go = 1'b0; d_go = 1'b0; s_go = 1'b0;
        m_a = '0; m_b = '0; m_frac = 1'b1; m_lim = AMAX;
        d_num = '0; d_den = '0; d_frac = 1'b1; d_lim = AMAX;
        case (cmd.step)
            ST_R2X:   begin m_go = 1'b1; m_a = 64'(a0_reg); m_b = 64'(a0_reg); m_frac = 1'b0; end
            ST_R2Y:   begin m_go = 1'b1; m_a = 64'(a1_reg); m_b = 64'(a1_reg); m_frac = 1'b0; end
            ST_R2Z:   begin m_go = 1'b1; m_a = 64'(a2_reg); m_b = 64'(a2_reg); m_frac = 1'b0; end
            ST_H2:    begin m_go = 1'b1; m_a = 64'(cfg.radius); m_b = 64'(cfg.radius);
                            m_frac = 1'b0; end
            ST_P1:    begin m_go = 1'b1; m_a = dq_reg; m_b = dq_reg; end
            ST_P2:    begin m_go = 1'b1; m_a = t_reg; m_b = dq_reg; end
            ST_P3:    begin m_go = 1'b1; m_a = 64'(cfg.poly6); m_b = t_reg; end
            ST_P4:    begin m_go = 1'b1; m_a = 64'(cfg.mass); m_b = t_reg; end
            ST_SQRT:  s_go = 1'b1;
            ST_HR2:   begin m_go = 1'b1; m_a = 64'(hr_reg); m_b = 64'(hr_reg); m_frac = 1'b0; end
            ST_QDIV:  begin d_go = 1'b1; d_num = t_reg; d_den = 64'(r_reg); d_frac = 1'b0;
                            d_lim = ALL1; end
            ST_CM:    begin m_go = 1'b1; m_a = 64'(spiky_mag); m_b = q_reg; end
            ST_GX:    begin m_go = 1'b1; m_a = 64'(a0_reg); m_b = cm_reg; end
            ST_GY:    begin m_go = 1'b1; m_a = 64'(a1_reg); m_b = cm_reg; end
            ST_GZ:    begin m_go = 1'b1; m_a = 64'(a2_reg); m_b = cm_reg; end
            ST_SQX, ST_SQY, ST_SQZ:
                      begin m_go = 1'b1; m_a = gm_reg; m_b = gm_reg; m_lim = SQMAX; end
            ST_TX:    begin m_go = 1'b1; m_a = sabs(gx_reg); m_b = sabs(gx_reg); m_lim = SQMAX; end
            ST_TY:    begin m_go = 1'b1; m_a = sabs(gy_reg); m_b = sabs(gy_reg); m_lim = SQMAX; end
            ST_TZ:    begin m_go = 1'b1; m_a = sabs(gz_reg); m_b = sabs(gz_reg); m_lim = SQMAX; end
            ST_KDIV:  begin d_go = 1'b1; d_num = 64'(cfg.mass); d_den = 64'(cfg.rho);
                            d_lim = SQMAX; end
            ST_KK:    begin m_go = 1'b1; m_a = kk_reg; m_b = kk_reg; m_lim = SQMAX; end
            ST_DEN:   begin m_go = 1'b1; m_a = 64'(tot_reg); m_b = kk_reg; m_lim = SQMAX; end
            ST_RATIO: begin d_go = 1'b1; d_num = 64'(dsum_reg); d_den = 64'(cfg.rho); end
            ST_LAM:   begin d_go = 1'b1; d_num = cmag_reg; d_den = den_reg;
                            d_lim = cpos_reg ? LPOS : LNEG; end
            default:  ;
        endcase
    end

    pbfd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(cmd.issue & m_go), .a(m_a), .b(m_b),
        .frac(m_frac), .limit(m_lim), .busy(m_busy), .res(m_res), .sat(m_sat)
    );

    pbfd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.issue & d_go), .num(d_num), .den(d_den),
        .frac(d_frac), .limit(d_lim), .busy(d_busy), .res(d_res), .sat(d_sat)
    );

    pbfd_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(cmd.issue & s_go), .v(r2_reg),
        .busy(s_busy), .res(s_res)
    );

    // write-back arithmetic
    always_comb
    begin
        unit_sat = (m_go & m_sat) | (d_go & d_sat);
        gneg     = cfg.spiky[31];
        case (cmd.step)
            ST_GY:   gneg = cfg.spiky[31] ^ neg_reg[1];
            ST_GZ:   gneg = cfg.spiky[31] ^ neg_reg[2];
            default: gneg = cfg.spiky[31] ^ neg_reg[0];
        endcase
        case (cmd.step)
            ST_GY:   acc_base = gy_reg;
            ST_GZ:   acc_base = gz_reg;
            ST_P4:   acc_base = dsum_reg;
            default: acc_base = gx_reg;
        endcase
        acc_res = sacc(acc_base, m_res, (cmd.step == ST_P4) ? 1'b0 : gneg, add_sat);
        if (cmd.step == ST_SQX || cmd.step == ST_SQY || cmd.step == ST_SQZ)
            add_res = usat(64'(gsq_reg), m_res, add_sat);
        else if (cmd.step == ST_TX)
            add_res = usat(64'(gsq_reg), m_res, add_sat);
        else if (cmd.step == ST_TY || cmd.step == ST_TZ)
            add_res = usat(64'(tot_reg), m_res, add_sat);
        else if (cmd.step == ST_DEN)
            add_res = usat(m_res, 64'(cfg.eps), add_sat);
        else if (cmd.step == ST_CM)
        begin
            add_res = '0;
            add_sat = m_res > AMAX3;
        end
        else if (cmd.step == ST_P4 || cmd.step == ST_GX || cmd.step == ST_GY ||
                 cmd.step == ST_GZ)
            add_res = '0;
        else
        begin
            add_res = '0;
            add_sat = 1'b0;
        end
        cm_next     = (m_res > AMAX3) ? AMAX : (m_res + (m_res << 1));
        lm_mag      = d_res;
        lambda_next = cpos_reg ? 32'(-lm_mag) : lm_mag[31:0];
        dens_clip   = 64'(dsum_reg) > 64'h0000_0000_7FFF_FFFF;
        out_free    = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a0_reg     <= ax;
            a1_reg     <= ay;
            a2_reg     <= az;
            neg_reg    <= {dz[32], dy[32], dx[32]};
            beyond_reg <= (ax > 32'(cfg.radius)) || (ay > 32'(cfg.radius)) ||
                          (az > 32'(cfg.radius));
            self_reg   <= is_self;
            last_reg   <= last_neighbor;
        end
        if (cmd.commit)
        begin
            case (cmd.step)
                ST_R2X:   r2_reg <= m_res;
                ST_R2Y,
                ST_R2Z:   r2_reg <= r2_reg + m_res;
                ST_H2:    dq_reg <= (m_res - r2_reg) >> FRAC_BITS;
                ST_P1,
                ST_P2,
                ST_P3,
                ST_HR2:   t_reg <= m_res;
                ST_SQRT:
                begin
                    r_reg  <= s_res;
                    hr_reg <= 31'(32'(cfg.radius) - s_res);
                end
                ST_QDIV:  q_reg <= d_res;
                ST_CM:    cm_reg <= cm_next;
                ST_GX,
                ST_GY,
                ST_GZ:    gm_reg <= m_res;
                ST_TX,
                ST_TY,
                ST_TZ:    tot_reg <= add_res[62:0];
                ST_KDIV,
                ST_KK:    kk_reg <= (cmd.step == ST_KK) ? m_res : d_res;
                ST_DEN:   den_reg <= add_res;
                ST_RATIO:
                begin
                    cpos_reg <= d_res > ONE;
                    cmag_reg <= (d_res > ONE) ? (d_res - ONE) : (ONE - d_res);
                end
                ST_LAM:
                begin
                    density_reg <= dens_clip ? 31'h7FFF_FFFF : dsum_reg[30:0];
                    lambda_reg  <= lambda_next;
                end
                default: ;
            endcase
        end
    end

    // run sums, sticky flag and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dsum_reg      <= '0;
            gx_reg        <= '0;
            gy_reg        <= '0;
            gz_reg        <= '0;
            gsq_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !(cmd.commit && cmd.step == ST_LAM))
                out_valid_reg <= 1'b0;
            if (cmd.commit)
            begin
                if (cmd.step != ST_LAM)
                    sat_reg <= sat_reg | unit_sat | add_sat;
                case (cmd.step)
                    ST_P4: dsum_reg <= acc_res;
                    ST_GX: gx_reg   <= acc_res;
                    ST_GY: gy_reg   <= acc_res;
                    ST_GZ: gz_reg   <= acc_res;
                    ST_SQX,
                    ST_SQY,
                    ST_SQZ: gsq_reg <= add_res[62:0];
                    ST_LAM:
                    begin
                        out_valid_reg <= 1'b1;
                        overflow_reg  <= sat_reg | unit_sat | dens_clip;
                        sat_reg       <= 1'b0;
                        dsum_reg      <= '0;
                        gx_reg        <= '0;
                        gy_reg        <= '0;
                        gz_reg        <= '0;
                        gsq_reg       <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        stat.busy      = m_busy | d_busy | s_busy;
        stat.far       = beyond_reg || (r2_reg > m_res);
        stat.skip_grad = self_reg || (r2_reg == 64'd0);
        stat.last      = last_reg;
        stat.out_free  = out_free;
    end

    assign out_valid = out_valid_reg;
    assign density   = density_reg;
    assign lambda    = lambda_reg;
    assign overflow  = overflow_reg;
endmodule

/* sv/pbfd_ctrl.sv */
// pbfd_ctrl: sequencer that walks the per-beat and end-of-run programme.
// Depends on pbfd_pkg.
module pbfd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  pbfd_pkg::stat_t stat,
    output pbfd_pkg::cmd_t  cmd,
    output logic            in_stall
);
    import pbfd_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ISSUE  = 2'd1;
    localparam logic [1:0] S_WAIT   = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       commit;

    always_comb
    begin
        commit     = (state_reg == S_WAIT) && !stat.busy &&
                     ((step_reg != ST_LAM) || stat.out_free);
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    state_next = S_ISSUE;
                    step_next  = ST_R2X;
                end
            S_ISSUE:
                state_next = S_WAIT;
            S_WAIT:
                if (commit)
                begin
                    state_next = S_ISSUE;
                    step_next  = step_reg + 5'd1;
                    case (step_reg)
                        ST_H2:   if (stat.far) state_next = S_DECIDE;
                        ST_P4:   if (stat.skip_grad) state_next = S_DECIDE;
                        ST_SQZ:  state_next = S_DECIDE;
                        ST_LAM:  state_next = S_IDLE;
                        default: ;
                    endcase
                end
            S_DECIDE:
                if (stat.last)
                begin
                    state_next = S_ISSUE;
                    step_next  = ST_TX;
                end
                else
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= ST_R2X;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && in_valid;
        cmd.issue  = state_reg == S_ISSUE;
        cmd.commit = commit;
        cmd.step   = step_reg;
    end

    assign in_stall = state_reg != S_IDLE;
endmodule

/* sv/pbf_density_lambda_accumulator.sv */
// pbf_density_lambda_accumulator: top level, configuration registers and
// sequencer/datapath wiring. Depends on pbfd_pkg, pbfd_ctrl, pbfd_datapath.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------
//  in      | in        | in_valid / in_stall | centre xyz, neighbour xyz, flags
//  out     | out       | out_valid/out_stall | density, lambda, overflow
//  cfg     | in        | APB psel/penable    | six kernel registers
//
// One neighbour beat at a time. A pair beyond the radius stops after the
// range test; an in-range pair runs the density steps and, unless self or
// coincident, the gradient steps; the beat flagged last then adds the lambda
// steps, which run on the shared 32x32 multiplier and bit-serial divider.
// Reset clears the sums, the sticky overflow, out_valid and overflow.
// A result waiting under out_stall does not block the next beats; only the
// write of the following result waits for the output register to drain.
module pbf_density_lambda_accumulator #(
    parameter int FRAC_BITS = 16,
    parameter int ACC_BITS  = 48
) (
    input  logic               clk,
    input  logic               rst_n,
    // neighbour beats
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic signed [31:0] neighbor_x,
    input  logic signed [31:0] neighbor_y,
    input  logic signed [31:0] neighbor_z,
    input  logic               is_self,
    input  logic               last_neighbor,
    // results
    output logic               out_valid,
    input  logic               out_stall,
    output logic [30:0]        density,
    output logic signed [31:0] lambda,
    output logic               overflow,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import pbfd_pkg::*;

    localparam logic [30:0] UNIT = 31'(64'd1 << FRAC_BITS);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    stat_t   stat;
    logic    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // kernel registers; writes must only arrive while the block is idle, which the block itself does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radius <= UNIT;
            cfg_reg.poly6  <= UNIT;
            cfg_reg.spiky  <= -signed'({1'b0, UNIT});
            cfg_reg.mass   <= UNIT;
            cfg_reg.rho    <= UNIT;
            cfg_reg.eps    <= EPS_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_RADIUS: cfg_reg.radius <= pwdata[30:0];
                REG_POLY6:  cfg_reg.poly6  <= pwdata[30:0];
                REG_SPIKY:  cfg_reg.spiky  <= signed'(pwdata);
                REG_MASS:   cfg_reg.mass   <= pwdata[30:0];
                REG_RHO:    cfg_reg.rho    <= pwdata[30:0];
                REG_EPS:    cfg_reg.eps    <= pwdata[30:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_RADIUS: prdata = {1'b0, cfg_reg.radius};
            REG_POLY6:  prdata = {1'b0, cfg_reg.poly6};
            REG_SPIKY:  prdata = cfg_reg.spiky;
            REG_MASS:   prdata = {1'b0, cfg_reg.mass};
            REG_RHO:    prdata = {1'b0, cfg_reg.rho};
            REG_EPS:    prdata = {1'b0, cfg_reg.eps};
            default:    prdata = '0;
        endcase
    end

    pbfd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .stat(stat),
        .cmd(cmd), .in_stall(in_stall)
    );

    pbfd_datapath #(.FRAC_BITS(FRAC_BITS), .ACC_BITS(ACC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cfg(cfg_reg),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .neighbor_x(neighbor_x), .neighbor_y(neighbor_y), .neighbor_z(neighbor_z),
        .is_self(is_self), .last_neighbor(last_neighbor), .out_stall(out_stall),
        .out_valid(out_valid), .density(density), .lambda(lambda),
        .overflow(overflow), .stat(stat)
    );
endmodule

/* sv/pbfd_chk.sv */
// pbfd_chk: port-level checks of the accumulator, bound to the top level.
// Depends on pbf_density_lambda_accumulator.
module pbfd_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [30:0]        density,
    input logic signed [31:0] lambda,
    input logic               overflow
);
    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(density) &&
                                   $stable(lambda) && $stable(overflow))
        else $error("result beat changed under stall");

    // an accepted beat always occupies the sequencer for a while
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again straight after a beat");

    // a result only appears while a beat is being worked on
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with the sequencer idle");
endmodule

bind pbf_density_lambda_accumulator pbfd_chk u_pbfd_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .density(density),
    .lambda(lambda), .overflow(overflow)
);

/* dv/pbf_density_lambda_accumulator_tb.sv */
// Self-checking bench for pbf_density_lambda_accumulator: neighbour beats in,
// density/lambda results out, APB register writes between phases.
// Depends on pbfd_pkg (register indexes) and the block's RTL only.
`timescale 1ns / 1ps

module pbf_density_lambda_accumulator_tb;
    import pbfd_pkg::*;

    localparam int          FRAC      = 16;
    localparam longint      ACC_LIM   = 64'h0000_7FFF_FFFF_FFFF;  // +-(2^47 - 1)
    localparam longint unsigned SQ_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint unsigned Q_ONE = 64'd1 << FRAC;
    localparam int          DRAIN     = 600;       // worst beat plus lambda, rounded up
    localparam longint      CYCLE_CAP = 64'd6_000_000;
    localparam int          BEATS     = 1950;
    localparam int          PHASES    = 6;

    // one neighbour beat as seen on the input ports
    typedef struct {
        logic signed [31:0] cx, cy, cz;
        logic signed [31:0] nx, ny, nz;
        logic               self_f;
        logic               last_f;
    } nbr_beat_t;

    typedef struct {
        logic [30:0]        dens;
        logic signed [31:0] lam;
        logic               ovf;
    } lambda_result_t;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the kernel registers and running sums.
    // note() folds one accepted beat into the sums and queues a result on
    // the closing beat; check() compares an output beat with the oldest.
    // ------------------------------------------------------------------
    class lambda_scoreboard;
        longint unsigned radius, poly6, mass, rho, eps;
        longint          spiky;
        longint          dens_acc, gx, gy, gz;
        longint unsigned gsq;
        bit              clipped;
        lambda_result_t  pending[$];

        function new();
            radius = 65536; poly6 = 65536; spiky = -65536;
            mass = 65536; rho = 65536; eps = 655;
            clear_sums();
        endfunction

        function void clear_sums();
            dens_acc = 0; gx = 0; gy = 0; gz = 0; gsq = 0; clipped = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_RADIUS: radius = {33'd0, val[30:0]};
                REG_POLY6:  poly6  = {33'd0, val[30:0]};
                REG_SPIKY:  spiky  = longint'($signed(val));
                REG_MASS:   mass   = {33'd0, val[30:0]};
                REG_RHO:    rho    = {33'd0, val[30:0]};
                REG_EPS:    eps    = {33'd0, val[30:0]};
                default: ;
            endcase
        endfunction

        // (a*b) >> F, clipped to lim
        function longint unsigned qmul(longint unsigned a, longint unsigned b,
                                       longint unsigned lim);
            logic [127:0] p;
            p = ({64'd0, a} * {64'd0, b}) >> FRAC;
            if (p > {64'd0, lim}) begin
                clipped = 1;
                return lim;
            end
            return p[63:0];
        endfunction

        // (num << F) / den, den of zero read as one LSB
        function longint unsigned qdiv(longint unsigned num, longint unsigned den,
                                       longint unsigned lim);
            logic [127:0] q;
            if (den == 0) den = 1;
            q = ({64'd0, num} << FRAC) / {64'd0, den};
            if (q > {64'd0, lim}) begin
                clipped = 1;
                return lim;
            end
            return q[63:0];
        endfunction

        function longint sadd(longint a, longint b);
            if (b > 0 && a > ACC_LIM - b) begin
                clipped = 1;
                return ACC_LIM;
            end
            if (b < 0 && a < -ACC_LIM - b) begin
                clipped = 1;
                return -ACC_LIM;
            end
            return a + b;
        endfunction

        function longint unsigned uadd(longint unsigned a, longint unsigned b);
            if (b > SQ_LIM || a > SQ_LIM - b) begin
                clipped = 1;
                return SQ_LIM;
            end
            return a + b;
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned r, t;
            r = 0;
            for (int i = 31; i >= 0; i--) begin
                t = r | (64'd1 << i);
                if (t * t <= v) r = t;
            end
            return r;
        endfunction

        function longint unsigned absv(longint v);
            return (v < 0) ? longint'(0) - v : v;
        endfunction

        function void note(nbr_beat_t b);
            longint          d[3];
            longint unsigned a[3], r2, h2, dq, t, r, hr, q, cm, gm, rr, tot, kk, den;
            longint unsigned ratio, cmag, lm;
            longint          c, g;
            bit              far, cneg, neg;
            lambda_result_t  res;
            d[0] = longint'(b.nx) - longint'(b.cx);
            d[1] = longint'(b.ny) - longint'(b.cy);
            d[2] = longint'(b.nz) - longint'(b.cz);
            far = 0;
            h2 = radius * radius;
            for (int k = 0; k < 3; k++) begin
                a[k] = absv(d[k]);
                if (a[k] > radius) far = 1;
            end
            if (!far) begin
                r2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
                if (r2 > h2) far = 1;
            end
            if (!far) begin
                dq = (h2 - r2) >> FRAC;
                t = qmul(dq, dq, ACC_LIM);
                t = qmul(t, dq, ACC_LIM);
                t = qmul(poly6, t, ACC_LIM);
                t = qmul(mass, t, ACC_LIM);
                dens_acc = sadd(dens_acc, longint'(t));
                // self entry and coincident pair add density only
                if (!b.self_f && r2 != 0) begin
                    r = root(r2);
                    hr = radius - r;
                    q = (hr * hr) / r;
                    cm = qmul(absv(spiky), q, ACC_LIM);
                    cneg = spiky < 0;
                    if (cm > ACC_LIM / 3) begin
                        clipped = 1;
                        cm = ACC_LIM;
                    end else begin
                        cm = cm * 3;
                    end
                    for (int k = 0; k < 3; k++) begin
                        gm = qmul(a[k], cm, ACC_LIM);
                        neg = cneg != (d[k] < 0);
                        g = neg ? -longint'(gm) : longint'(gm);
                        case (k)
                            0: gx = sadd(gx, g);
                            1: gy = sadd(gy, g);
                            default: gz = sadd(gz, g);
                        endcase
                        gsq = uadd(gsq, qmul(gm, gm, SQ_LIM));
                    end
                end
            end
            if (!b.last_f) return;

            rr = (rho != 0) ? rho : 1;
            tot = gsq;
            tot = uadd(tot, qmul(absv(gx), absv(gx), SQ_LIM));
            tot = uadd(tot, qmul(absv(gy), absv(gy), SQ_LIM));
            tot = uadd(tot, qmul(absv(gz), absv(gz), SQ_LIM));
            kk = qdiv(mass, rr, SQ_LIM);
            kk = qmul(kk, kk, SQ_LIM);
            den = qmul(tot, kk, SQ_LIM);
            den = uadd(den, eps);
            if (den == 0) den = 1;
            ratio = qdiv(longint'(dens_acc), rr, ACC_LIM);
            c = longint'(ratio) - longint'(Q_ONE);
            cmag = absv(c);
            lm = qdiv(cmag, den, (c > 0) ? 64'h8000_0000 : 64'h7FFF_FFFF);
            if (dens_acc > 64'h7FFF_FFFF) begin
                clipped = 1;
                res.dens = 31'h7FFF_FFFF;
            end else begin
                res.dens = dens_acc[30:0];
            end
            res.lam = (c > 0) ? 32'(longint'(0) - longint'(lm)) : lm[31:0];
            res.ovf = clipped;
            pending.insert(pending.size(), res);
            clear_sums();
        endfunction

        // empty string when the beat matches
        function string check(logic [30:0] dens, logic signed [31:0] lam, logic ovf);
            lambda_result_t e;
            string          msg;
            if (pending.size() == 0) return "result with none expected";
            e = pending.pop_front();
            msg = "";
            if (dens !== e.dens)
                msg = {msg, $sformatf(" density %h exp %h", dens, e.dens)};
            if (lam !== e.lam)
                msg = {msg, $sformatf(" lambda %h exp %h", lam, e.lam)};
            if (ovf !== e.ovf)
                msg = {msg, $sformatf(" overflow %b exp %b", ovf, e.ovf)};
            return msg;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Ports; everything starts at a known value
    // ------------------------------------------------------------------
    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic signed [31:0] center_x = 0, center_y = 0, center_z = 0;
    logic signed [31:0] neighbor_x = 0, neighbor_y = 0, neighbor_z = 0;
    logic               is_self = 0;
    logic               last_neighbor = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [30:0]        density;
    logic signed [31:0] lambda;
    logic               overflow;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [4:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;

    pbf_density_lambda_accumulator u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .neighbor_x(neighbor_x), .neighbor_y(neighbor_y), .neighbor_z(neighbor_z),
        .is_self(is_self), .last_neighbor(last_neighbor),
        .out_valid(out_valid), .out_stall(out_stall),
        .density(density), .lambda(lambda), .overflow(overflow),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lambda_scoreboard sb = new();
    int     mismatches = 0;
    int     beats_sent = 0;
    longint cycles = 0;
    bit     tx_quiet = 0;   // sender runs back to back
    bit     rx_quiet = 0;   // receiver never stalls

    initial begin
        forever #5 clk = ~clk;
    end

    // run-length guard
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report(string msg);
        $display("[%0t] mismatch:%s", $realtime, msg);
        mismatches++;
    endtask

    // Result side: values read right after the edge are still the pre-edge ones
    always @(posedge clk) begin
        string msg;
        if (rst_n && out_valid && !out_stall) begin
            msg = sb.check(density, lambda, overflow);
            if (msg != "") report(msg);
        end
    end

    // Receiver back-pressure: a fresh random stall before each result beat
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            n = rx_quiet ? 0 : $urandom_range(0, 9);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // APB write: setup, then access; pready is sampled on the access edge
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Put one beat on the bus after a random gap and hold it until taken.
    // Called at an edge; in_valid gets one assignment per edge.
    task automatic send_beat(nbr_beat_t b);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        center_x      <= b.cx;
        center_y      <= b.cy;
        center_z      <= b.cz;
        neighbor_x    <= b.nx;
        neighbor_y    <= b.ny;
        neighbor_z    <= b.nz;
        is_self       <= b.self_f;
        last_neighbor <= b.last_f;
        do @(posedge clk); while (in_stall);
        sb.note(b);
        beats_sent++;
    endtask

    task automatic send_pair(logic signed [31:0] cx, cy, cz, ox, oy, oz,
                             logic self_f, logic last_f);
        nbr_beat_t b;
        b.cx = cx; b.cy = cy; b.cz = cz;
        b.nx = cx + ox; b.ny = cy + oy; b.nz = cz + oz;
        b.self_f = self_f;
        b.last_f = last_f;
        send_beat(b);
    endtask

    // Offset on one axis scaled to the current radius; mostly in range
    function automatic logic signed [31:0] pick_offset();
        int unsigned sel, mag;
        longint unsigned h;
        h = sb.radius;
        sel = $urandom_range(0, 99);
        if (sel < 60)      mag = $urandom_range(0, 32'(h / 2));
        else if (sel < 80) mag = $urandom_range(0, 32'(h));
        else if (sel < 88) mag = 0;
        else if (sel < 94) mag = 32'(h) + $urandom_range(0, 3);
        else return $urandom;
        return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
    endfunction

    // A neighbour run for one particle: well-formed (one self entry, last
    // flag on the final beat) most of the time, otherwise random flags
    task automatic send_run();
        int                 n, self_at;
        bit                 noisy;
        logic signed [31:0] cx, cy, cz;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        self_at = $urandom_range(0, n - 1);
        noisy = $urandom_range(0, 9) == 0;
        if ($urandom_range(0, 3) == 0) begin
            cx = $urandom; cy = $urandom; cz = $urandom;
        end else begin
            cx = $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
            cy = $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
            cz = $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
        end
        tx_quiet = $urandom_range(0, 3) == 0;
        for (int i = 0; i < n; i++) begin
            if (noisy)
                send_pair(cx, cy, cz, pick_offset(), pick_offset(), pick_offset(),
                          $urandom_range(0, 1), $urandom_range(0, 3) == 0);
            else if (i == self_at)
                send_pair(cx, cy, cz, 0, 0, 0, 1'b1, i == n - 1);
            else
                send_pair(cx, cy, cz, pick_offset(), pick_offset(), pick_offset(),
                          1'b0, i == n - 1);
        end
    endtask

    // Let every expected result drain, then the tail of a silent beat
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic load_kernel(logic [31:0] h, p6, sp, m, rho, eps);
        reg_write(REG_RADIUS, h);
        reg_write(REG_POLY6, p6);
        reg_write(REG_SPIKY, sp);
        reg_write(REG_MASS, m);
        reg_write(REG_RHO, rho);
        reg_write(REG_EPS, eps);
    endtask

    initial begin
        int target;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats under reset values (h = 1.0)
        tx_quiet = 0;
        send_pair(0, 0, 0, 0, 0, 0, 1'b1, 1'b0);                      // self entry
        send_pair(0, 0, 0, 32'sh8000, 0, 0, 1'b0, 1'b0);              // half radius
        send_pair(0, 0, 0, 0, 0, 0, 1'b0, 1'b0);                      // coincident
        send_pair(0, 0, 0, 32'sh1_0001, 0, 0, 1'b0, 1'b0);            // one axis beyond
        send_pair(0, 0, 0, 32'shCCCC, 32'shCCCC, 0, 1'b0, 1'b0);      // r beyond h
        send_pair(0, 0, 0, 32'sh1_0000, 0, 0, 1'b0, 1'b0);            // exactly h
        send_pair(0, 0, 0, -32'sh4CCC, -32'sh6666, -32'sh3333, 1'b0, 1'b1);
        send_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  1, 1, 1, 1'b0, 1'b1);                              // wraps to far
        send_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  0, 0, 0, 1'b1, 1'b1);
        send_pair(32'sh1234_5678, -32'sh0FED_CBA9, 32'sh0000_FFFF,
                  32'sh4000_0000, 0, 0, 1'b0, 1'b1);                  // lone far beat
        send_pair(-1, -1, -1, 32'sh0000_7FFF, 32'sh0000_2AAA, 32'sh0000_5555,
                  1'b0, 1'b1);

        // sender holds off until every result is back, before the random phases
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                settle();
                case (ph)
                    // hot kernel: biggest coefficients, smallest rho and eps
                    1: load_kernel(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                   32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
                    // widest radius, zero poly6 and mass, largest spiky, rho and eps
                    2: load_kernel(32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF,
                                   32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
                    // a plausible fluid set-up
                    3: load_kernel(32'h0002_0000, 32'h0001_8000, 32'h0003_0000,
                                   32'h0000_8000, 32'h0000_C000, 32'h0000_0100);
                    // rho of zero reads as one LSB; eps of one LSB
                    4: load_kernel(32'h0000_4000, 32'h0010_0000, -32'sh0010_0000,
                                   32'h0002_0000, 32'h8000_0000, 32'h0000_0001);
                    default: load_kernel($urandom_range(1, 32'h0040_0000), $urandom,
                                         $urandom, $urandom, $urandom, $urandom);
                endcase
            end
            rx_quiet = (ph % 3) == 2;
            target = (BEATS * (ph + 1)) / PHASES;
            while (beats_sent < target) send_run();
        end

        settle();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
